/* src/wps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wps_pkg
// Shared constants and types of the window pooling block.
// ----------------------------------------------------------------------------
package wps_pkg;

    localparam int MEM_DEPTH_DEF    = 4096;
    localparam int DATA_WIDTH_DEF   = 32;
    localparam int SPATIAL_DIMS_DEF = 2;

    localparam int OUT_W   = 48;
    localparam int IDX_W   = 12;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 13;
    localparam int CIDX_W  = 3;

    localparam logic [CIDX_W-1:0] REG_POOL_MODE = 3'd0;
    localparam logic [CIDX_W-1:0] REG_IN_WIDTH  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_CHANNELS  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_WIN_H     = 3'd3;
    localparam logic [CIDX_W-1:0] REG_WIN_W     = 3'd4;
    localparam logic [CIDX_W-1:0] REG_STEP_H    = 3'd5;
    localparam logic [CIDX_W-1:0] REG_STEP_W    = 3'd6;
    localparam logic [CIDX_W-1:0] REG_OUT_WIDTH = 3'd7;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_POOL = 1'b1;

    typedef struct packed {
        logic        pool_mode;
        logic [12:0] in_width;
        logic [8:0]  channels;
        logic [4:0]  win_h;
        logic [4:0]  win_w;
        logic [4:0]  step_h;
        logic [4:0]  step_w;
        logic [12:0] out_width;
    } t_cfg;

    // Memory request from the sequencer to the store.
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage
`default_nettype wire

/* src/window_pool_sum_max.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// window_pool_sum_max
// Sum or max pooling over a tensor held in an internal store.
// ----------------------------------------------------------------------------
// Channel  | Handshake            | Payload
// in       | i_valid / o_ready    | i_func, i_in_index, i_value, i_out_index
// out      | o_valid / i_ready    | o_pooled_value
// cfg      | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A load beat writes the store in its accept cycle, and loads can follow back to back.
// A pool beat holds the input through the accept cycle, the bit-serial divider that
// splits out_index when SPATIAL_DIMS >= 2, a hand-off, the address setup states S_MUL1 and
// S_MUL2, one store read per element, a drain of the last read and the publish.
// Synchronous reset clears control and configuration; the store is not cleared.
// A finished result waits in the output register and a new beat is taken meanwhile;
// a second pool that finishes while the register is still full holds off the input.
// MEM_DEPTH must be a power of two, so store addresses wrap by dropping high bits.
// ----------------------------------------------------------------------------
module window_pool_sum_max #(
    parameter int MEM_DEPTH    = wps_pkg::MEM_DEPTH_DEF,
    parameter int DATA_WIDTH   = wps_pkg::DATA_WIDTH_DEF,
    parameter int SPATIAL_DIMS = wps_pkg::SPATIAL_DIMS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire                  i_func,
    input  wire [11:0]           i_in_index,
    input  wire signed [31:0]    i_value,
    input  wire [11:0]           i_out_index,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic signed [47:0]   o_pooled_value,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [2:0]            i_cfg_index,
    input  wire [12:0]           i_cfg_data
);
    localparam int AW    = $clog2(MEM_DEPTH);
    localparam int ACC_W = 52;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_MUL1 = 6'b000100,
        S_MUL2 = 6'b001000,
        S_RUN  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state;
    wps_pkg::t_cfg r_cfg;

    logic        acc_in;
    logic        pool_in;
    logic        div_done;
    logic [11:0] div_q;
    logic [12:0] div_r;
    logic        div_start;

    logic [11:0]   r_oy;
    logic [12:0]   r_ox;
    logic [21:0]   r_row_span;   // in_width*channels
    logic [16:0]   r_base_y;
    logic [17:0]   r_base_x;
    logic [AW-1:0] r_row_addr;   // start of current window row
    logic [AW-1:0] r_kx_addr;    // start of current window column
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_rs_step;
    logic [AW-1:0] r_ch_step;
    logic [8:0]    r_c;
    logic [4:0]    r_kx;
    logic [4:0]    r_ky;
    logic [4:0]    r_wh;
    logic          r_rd_pend;    // read data valid this cycle
    logic signed [ACC_W-1:0] r_acc;

    logic [DATA_WIDTH-1:0]   mem_rdata;
    wps_pkg::t_mem_ctl       mem_ctl;
    logic [AW-1:0]           mem_addr;
    logic [31:0]             load_addr_ext;
    logic [AW-1:0]           base_addr;
    logic signed [ACC_W-1:0] elem;
    logic signed [ACC_W-1:0] acc_init;
    logic [47:0]             sat_value;
    logic                    last_elem;
    logic                    win_empty;
    logic                    publish;

    // Configuration.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{pool_mode: 1'b0, in_width: 13'd1, channels: 9'd1, win_h: 5'd1,
                       win_w: 5'd1, step_h: 5'd1, step_w: 5'd1, out_width: 13'd1};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wps_pkg::REG_POOL_MODE: r_cfg.pool_mode <= i_cfg_data[0];
                wps_pkg::REG_IN_WIDTH:  r_cfg.in_width  <= i_cfg_data;
                wps_pkg::REG_CHANNELS:  r_cfg.channels  <= i_cfg_data[8:0];
                wps_pkg::REG_WIN_H:     r_cfg.win_h     <= i_cfg_data[4:0];
                wps_pkg::REG_WIN_W:     r_cfg.win_w     <= i_cfg_data[4:0];
                wps_pkg::REG_STEP_H:    r_cfg.step_h    <= i_cfg_data[4:0];
                wps_pkg::REG_STEP_W:    r_cfg.step_w    <= i_cfg_data[4:0];
                wps_pkg::REG_OUT_WIDTH: r_cfg.out_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign acc_in  = i_valid && o_ready;
    assign pool_in = acc_in && (i_func == wps_pkg::FUNC_POOL);

    // Divider for out_index.
    assign div_start = pool_in && (SPATIAL_DIMS >= 2);

    wps_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (i_out_index),
        .i_den  (r_cfg.out_width),
        .o_done (div_done),
        .o_quo  (div_q),
        .o_rem  (div_r)
    );

    // Only the low address bits matter, so the products are kept at that width.
    assign base_addr = AW'(r_base_y * r_row_span) + AW'(r_base_x * r_cfg.channels);

    assign load_addr_ext = 32'(i_in_index);

    always_comb begin
        mem_ctl  = '0;
        mem_addr = r_addr;
        if (acc_in && i_func == wps_pkg::FUNC_LOAD) begin
            mem_ctl.we = 1'b1;
            mem_addr   = load_addr_ext[AW-1:0];
        end else if (r_state == S_RUN) begin
            mem_ctl.re = 1'b1;
        end
    end

    wps_store #(.MEM_DEPTH(MEM_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_store (
        .i_clk  (i_clk),
        .i_ctl  (mem_ctl),
        .i_addr (mem_addr),
        .i_wdata(i_value[DATA_WIDTH-1:0]),
        .o_rdata(mem_rdata)
    );

    assign elem     = {{(ACC_W-DATA_WIDTH){mem_rdata[DATA_WIDTH-1]}}, mem_rdata};
    assign acc_init = r_cfg.pool_mode
                    ? {{(ACC_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}} : '0;

    // A sum beyond the 48-bit range clips to the nearest end.
    always_comb begin
        if ((&r_acc[ACC_W-1:47]) || !(|r_acc[ACC_W-1:47])) begin
            sat_value = r_acc[47:0];
        end else if (r_acc[ACC_W-1]) begin
            sat_value = {1'b1, 47'd0};
        end else begin
            sat_value = {1'b0, {47{1'b1}}};
        end
    end

    assign last_elem = (r_c + 9'd1 == r_cfg.channels) && (r_kx + 5'd1 == r_cfg.win_w)
                       && (r_ky + 5'd1 == r_wh);
    assign win_empty = (r_cfg.channels == 9'd0) || (r_cfg.win_w == 5'd0) || (r_wh == 5'd0);
    assign publish   = (r_state == S_DONE) && !r_rd_pend && (!o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            o_valid   <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= (r_state == S_RUN);
            if (publish) begin
                o_pooled_value <= sat_value;
                o_valid        <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            if (pool_in) begin
                r_acc <= acc_init;
            end else if (r_rd_pend) begin
                if (r_cfg.pool_mode) begin
                    if (elem > r_acc) r_acc <= elem;
                end else begin
                    r_acc <= r_acc + elem;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (pool_in) begin
                        r_row_span <= 22'(r_cfg.in_width) * 22'(r_cfg.channels);
                        r_wh <= (SPATIAL_DIMS >= 2) ? r_cfg.win_h : 5'd1;
                        if (SPATIAL_DIMS >= 2) begin
                            r_state <= S_DIV;
                        end else begin
                            r_oy <= '0;
                            r_ox <= {1'b0, i_out_index};
                            r_state <= S_MUL1;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_oy <= div_q;
                        r_ox <= div_r;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_base_y <= 17'(r_oy) * 17'(r_cfg.step_h);
                    r_base_x <= 18'(r_ox) * 18'(r_cfg.step_w);
                    r_state  <= S_MUL2;
                end
                S_MUL2: begin
                    r_row_addr <= base_addr;
                    r_kx_addr  <= base_addr;
                    r_addr     <= base_addr;
                    r_rs_step  <= AW'(r_row_span);
                    r_ch_step  <= AW'(r_cfg.channels);
                    r_c  <= '0;
                    r_kx <= '0;
                    r_ky <= '0;
                    r_state <= win_empty ? S_DONE : S_RUN;
                end
                S_RUN: begin
                    if (last_elem) begin
                        r_state <= S_DONE;
                    end else if (r_c + 9'd1 != r_cfg.channels) begin
                        r_c <= r_c + 9'd1;
                        r_addr <= r_addr + AW'(1);
                    end else if (r_kx + 5'd1 != r_cfg.win_w) begin
                        r_c <= '0;
                        r_kx <= r_kx + 5'd1;
                        r_kx_addr <= r_kx_addr + r_ch_step;
                        r_addr <= r_kx_addr + r_ch_step;
                    end else begin
                        r_c <= '0; r_kx <= '0;
                        r_ky <= r_ky + 5'd1;
                        r_row_addr <= r_row_addr + r_rs_step;
                        r_kx_addr <= r_row_addr + r_rs_step;
                        r_addr <= r_row_addr + r_rs_step;
                    end
                end
                S_DONE: begin
                    // The last read lands the cycle after S_RUN, then the result goes out.
                    if (publish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_no_read_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_ctl.re) else $error("read while idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_pooled_value)))
        else $error("result dropped");
endmodule
`default_nettype wire

/* src/wps_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wps_store
// Tensor store: up to one write and one read a cycle, registered read data.
// ----------------------------------------------------------------------------
module wps_store #(
    parameter int MEM_DEPTH  = wps_pkg::MEM_DEPTH_DEF,
    parameter int DATA_WIDTH = wps_pkg::DATA_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire wps_pkg::t_mem_ctl       i_ctl,
    input  wire [$clog2(MEM_DEPTH)-1:0]  i_addr,
    input  wire [DATA_WIDTH-1:0]         i_wdata,
    output logic [DATA_WIDTH-1:0]        o_rdata
);
    logic [DATA_WIDTH-1:0] r_mem [MEM_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.re) begin
            o_rdata <= r_mem[i_addr];
        end
    end
endmodule
`default_nettype wire

/* src/wps_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wps_divider
// Restoring divider, one quotient bit a cycle, splits the output index.
// ----------------------------------------------------------------------------
module wps_divider (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire [11:0]  i_num,
    input  wire [12:0]  i_den,
    output logic        o_done,
    output logic [11:0] o_quo,
    output logic [12:0] o_rem
);
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic [11:0] r_q;
    logic [12:0] r_r;
    logic [12:0] r_d;
    logic [13:0] n_trial;

    assign n_trial = {r_r, r_q[11]} - {1'b0, r_d};
    assign o_quo = r_q;
    assign o_rem = r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_num;
                r_r    <= '0;
                r_d    <= (i_den == '0) ? 13'd1 : i_den;
            end else if (r_busy) begin
                if (!n_trial[13]) begin
                    r_r <= n_trial[12:0];
                    r_q <= {r_q[10:0], 1'b1};
                end else begin
                    r_r <= {r_r[11:0], r_q[11]};
                    r_q <= {r_q[10:0], 1'b0};
                end
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd11) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire
